### rtl/fpbe_pkg.sv
// ----------------------------------------------------------------------------
// fpbe_pkg
// Shared widths, constants and control types of the frame pair brightness
// equalizer.
// ----------------------------------------------------------------------------
package fpbe_pkg;

    localparam int CH_W      = 8;                 // one color channel
    localparam int PIX_W     = 3 * CH_W;          // one BGR pixel
    localparam int PAIR_W    = 2 * PIX_W;         // first pixel, then second
    localparam int SUM_W     = 30;                // per-frame channel sum
    localparam int GAIN_W    = 25;                // unsigned 9.16
    localparam int GAIN_FRAC = 16;

    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32'h0002_0000);  // 2.0
    localparam logic [GAIN_W-1:0] GAIN_CLAMP = GAIN_W'(32'h0100_0000);  // 256.0

    // pass selector carried on tuser
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_APPLY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic acc;        // add accepted word to the frame sums
        logic load_out;   // load accepted word into the output register
        logic div_start;  // latch sums into divider, pick darker frame, clear sums
        logic gain_load;  // take the finished quotient as new gain
    } fpbe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } fpbe_sts_t;

endpackage

### rtl/fpbe_div.sv
// ----------------------------------------------------------------------------
// fpbe_div
// Bit-serial restoring divider: gain = (bright << 17) / dark, clamped at 256.0.
// ----------------------------------------------------------------------------
module fpbe_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fpbe_pkg::SUM_W-1:0]    bright,
    input  logic [fpbe_pkg::SUM_W-1:0]    dark,
    output logic                          done,
    output logic [fpbe_pkg::GAIN_W-1:0]   quot
);
    import fpbe_pkg::*;

    localparam int STEPS = GAIN_W;
    localparam int CNT_W = $clog2(STEPS);
    // dividend bits below the initial remainder: low 8 bits of bright, then zeros
    localparam int LOW_BITS = GAIN_W - (GAIN_FRAC + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     dvs_reg, dvs_next;
    logic [GAIN_W-1:0]    num_reg, num_next;
    logic [GAIN_W-1:0]    quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;
    logic [SUM_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, num_reg[GAIN_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
            dvs_next  = dark;
            // quotient would reach 2^25 (covers dark == 0): clamp
            ovf_next  = {8'b0, bright} >= {dark, 8'b0};
            rem_next  = SUM_W'(bright[SUM_W-1:LOW_BITS]);
            num_next  = {bright[LOW_BITS-1:0], (GAIN_FRAC + 1)'(0)};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[GAIN_W-2:0], 1'b0};
            quo_next = {quo_reg[GAIN_W-2:0], fits};
            rem_next = fits ? SUM_W'(trial - {1'b0, dvs_reg}) : trial[SUM_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = (ovf_reg || quo_reg > GAIN_CLAMP) ? GAIN_CLAMP : quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

### rtl/fpbe_datapath.sv
// ----------------------------------------------------------------------------
// fpbe_datapath
// Frame sums, gain and darker-frame registers, channel scaling, output word.
// ----------------------------------------------------------------------------
module fpbe_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpbe_pkg::fpbe_cmd_t           cmd,
    output fpbe_pkg::fpbe_sts_t           sts,
    input  logic [fpbe_pkg::PAIR_W-1:0]   in_data,
    input  logic                          in_last,
    output logic [fpbe_pkg::PAIR_W-1:0]   out_data,
    output logic                          out_scaled,
    output logic                          out_last
);
    import fpbe_pkg::*;

    localparam int PROD_W = CH_W + GAIN_W + 1;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

    logic [SUM_W-1:0]   first_sum_reg, first_sum_next;
    logic [SUM_W-1:0]   second_sum_reg, second_sum_next;
    logic [GAIN_W-1:0]  gain_reg;
    logic               darker_reg;
    logic [PAIR_W-1:0]  out_data_reg;
    logic               out_scaled_reg;
    logic               out_last_reg;

    logic [PIX_W-1:0]   first_pix, second_pix, dark_pix, scaled_pix;
    logic               second_darker;
    logic [SUM_W-1:0]   bright_sum, dark_sum;
    logic [GAIN_W-1:0]  quot;

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] acc,
                                                 input logic [PIX_W-1:0] pix);
        logic [CH_W+1:0] add;
        logic [SUM_W:0]  s;
        add = {2'b0, pix[CH_W-1:0]} + {2'b0, pix[2*CH_W-1:CH_W]}
            + {2'b0, pix[3*CH_W-1:2*CH_W]};
        s = {1'b0, acc} + (SUM_W + 1)'(add);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] scale_ch(input logic [CH_W-1:0] c,
                                                 input logic [GAIN_W-1:0] g);
        logic [PROD_W-1:0] p;
        p = PROD_W'(c) * PROD_W'(g) + ROUND_HALF;
        if (p[PROD_W-1:GAIN_FRAC] > (PROD_W - GAIN_FRAC)'(8'hFF))
            return {CH_W{1'b1}};
        else
            return p[GAIN_FRAC +: CH_W];
    endfunction

    assign first_pix  = in_data[PIX_W-1:0];
    assign second_pix = in_data[PAIR_W-1:PIX_W];

    // ---- sums
    always_comb
    begin
        first_sum_next  = first_sum_reg;
        second_sum_next = second_sum_reg;
        if (cmd.div_start)
        begin
            first_sum_next  = '0;
            second_sum_next = '0;
        end
        else if (cmd.acc)
        begin
            first_sum_next  = sum_add(first_sum_reg, first_pix);
            second_sum_next = sum_add(second_sum_reg, second_pix);
        end
    end

    // first frame wins a tie
    assign second_darker = first_sum_reg > second_sum_reg;
    assign bright_sum    = second_darker ? first_sum_reg : second_sum_reg;
    assign dark_sum      = second_darker ? second_sum_reg : first_sum_reg;

    fpbe_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .bright (bright_sum),
        .dark   (dark_sum),
        .done   (sts.div_done),
        .quot   (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sum_reg  <= '0;
            second_sum_reg <= '0;
            gain_reg       <= GAIN_RESET;
            darker_reg     <= 1'b0;
        end
        else
        begin
            first_sum_reg  <= first_sum_next;
            second_sum_reg <= second_sum_next;
            if (cmd.div_start)
                darker_reg <= second_darker;
            if (cmd.gain_load)
                gain_reg <= quot;
        end
    end

    // ---- scaling: only the darker frame goes through the multipliers
    assign dark_pix = darker_reg ? second_pix : first_pix;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            scaled_pix[i*CH_W +: CH_W] = scale_ch(dark_pix[i*CH_W +: CH_W], gain_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= darker_reg ? {scaled_pix, first_pix} : {second_pix, scaled_pix};
            out_scaled_reg <= darker_reg;
            out_last_reg   <= in_last;
        end
    end

    assign out_data   = out_data_reg;
    assign out_scaled = out_scaled_reg;
    assign out_last   = out_last_reg;

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_CLAMP)
        else $error("gain above clamp");

endmodule

### rtl/fpbe_ctrl.sv
// ----------------------------------------------------------------------------
// fpbe_ctrl
// Handshake and sequencing: streaming, gain division stall, output valid.
// ----------------------------------------------------------------------------
module fpbe_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_action,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fpbe_pkg::fpbe_cmd_t   cmd,
    input  fpbe_pkg::fpbe_sts_t   sts
);
    import fpbe_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_START,
        S_DIV
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == S_RUN) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.acc       = accept && (in_action == ACT_ACCUM);
        cmd.load_out  = accept && (in_action == ACT_APPLY);
        cmd.div_start = state_reg == S_START;
        cmd.gain_load = (state_reg == S_DIV) && sts.div_done;

        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (cmd.acc && in_last)
                    state_next = S_START;
            end
            S_START:
                state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_RUN;
            end
            default:
                state_next = S_RUN;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && in_last) |=> !in_ready)
        else $error("input not stalled for gain division");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIV)
        else $error("divider result outside division state");

endmodule

### rtl/frame_pair_brightness_equalizer_unit.sv
// ----------------------------------------------------------------------------
// frame_pair_brightness_equalizer_unit
// Brightness equalizer for a pair of aligned BGR frames.
// ----------------------------------------------------------------------------
// Each input word is one pixel pair. tuser = 0 marks an accumulate pass word:
// its channels are added to a saturating 30-bit sum per frame and no output
// word is made. tlast on an accumulate word ends the pass: the darker frame is
// picked (first frame on a tie), gain = 2 * bright / dark is computed in
// unsigned 9.16 (truncated, clamped at 256.0, and 256.0 when dark is zero),
// and both sums are cleared. tuser = 1 marks an apply pass word: one output
// word follows, the darker frame's channels multiplied by the gain, rounded
// half up and saturated to 255, the other frame unchanged. Before any
// accumulate pass the gain is 2.0 on the first frame.
// Rate: one word per clock in both passes while the output side keeps up; the
// output register lets a new word in while the previous result is taken.
// After the last accumulate word the input stalls while the bit-serial
// restoring divider works out the 25 gain bits, one bit per cycle.
// ----------------------------------------------------------------------------
module frame_pair_brightness_equalizer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // first_blue, first_green, first_red, second_blue, second_green, second_red
    input  logic [fpbe_pkg::PAIR_W-1:0]   s_axis_tdata,
    // action
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,    // frame_end
    // output words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_first_blue, out_first_green, out_first_red,
    // out_second_blue, out_second_green, out_second_red
    output logic [fpbe_pkg::PAIR_W-1:0]   m_axis_tdata,
    // scaled_second
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast     // out_last
);
    import fpbe_pkg::*;

    fpbe_cmd_t cmd;
    fpbe_sts_t sts;

    // sequencing and handshake
    fpbe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // sums, gain division, scaling and output register
    fpbe_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .out_data   (m_axis_tdata),
        .out_scaled (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule
